### rtl/core/rvg_pkg.sv
package rvg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int MAG_W      = 17;
    localparam int SQ_W       = 31;
    localparam int MEAN_W     = 32;
    localparam int SQRT_STEPS = 16;
    localparam int SQ_REM_W   = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd5500;
    localparam logic [CFG_DATA_W-1:0] RELEASE_RESET   = 16'd250;
    localparam logic [LEVEL_W-1:0]    ELAPSED_MAX     = 16'hFFFF;
    localparam logic [LEVEL_W-1:0]    LEVEL_FULL      = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd1;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } state_t;

endpackage

### rtl/core/rms_voice_gate_with_hold_top.sv
// A tick goes from idle straight to the emit state; a sample that does not close a
// block passes through the square and accumulate states; a closing sample then also runs
// the divide and the square root before emit. Emit holds while a result waits on m_tready;
// the divide and the square root share a single subtractor, one bit a cycle.
// Reset (aresetn low at a clock edge): sum, count and level clear, the hold counter
// saturates so the gate starts silent, and both registers return to their defaults.
module rms_voice_gate_with_hold_top #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rvg_pkg::SAMPLE_W-1:0]    s_tdata,   // sample
    input  logic                            s_tuser,   // cmd
    input  logic                            s_tlast,   // last_in_block
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rvg_pkg::LEVEL_W-1:0]     m_tdata,   // rms_level
    output logic                            m_tuser,   // talking
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rvg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rvg_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W  = MEAN_W + $clog2(MAX_BLOCK);
    localparam int UNIT_W = (CNT_W + 1 > SQ_REM_W) ? CNT_W + 1 : SQ_REM_W;
    localparam int STEP_W = $clog2(SUM_W);

    state_t                  state_reg, state_next;
    logic [CFG_DATA_W-1:0]   threshold_reg, threshold_next;
    logic [CFG_DATA_W-1:0]   release_reg, release_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic [LEVEL_W-1:0]      elapsed_reg, elapsed_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    last_reg, last_next;
    logic [UNIT_W-1:0]       rem_reg, rem_next;
    logic [LEVEL_W-1:0]      root_reg, root_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]      out_level_reg, out_level_next;
    logic                    out_talk_reg, out_talk_next;

    logic [UNIT_W-1:0]       unit_a, unit_b;
    logic [UNIT_W:0]         unit_diff;
    logic                    unit_ok;
    logic [2*MAG_W-1:0]      product;
    logic [CNT_W-1:0]        count_inc;
    logic                    in_fire;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_level_reg;
    assign m_tuser   = out_talk_reg;

    assign product   = mag_reg * mag_reg;
    assign count_inc = count_reg + CNT_W'(1);

    // Shared subtractor for the divide and the square root.
    always_comb begin
        if (state_reg == ST_SQRT) begin
            unit_a = {rem_reg[UNIT_W-3:0], sum_reg[MEAN_W-1 -: 2]};
            unit_b = UNIT_W'({root_reg, 2'b01});
        end else begin
            unit_a = {rem_reg[UNIT_W-2:0], sum_reg[SUM_W-1]};
            unit_b = UNIT_W'(count_reg);
        end
        unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
        unit_ok   = !unit_diff[UNIT_W];
    end

    always_comb begin
        state_next     = state_reg;
        threshold_next = threshold_reg;
        release_next   = release_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        elapsed_next   = elapsed_reg;
        mag_next       = mag_reg;
        sq_next        = sq_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_talk_next  = out_talk_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_next = cfg_data;
                REG_RELEASE:   release_next   = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    last_next = s_tlast;
                    mag_next  = s_tdata[SAMPLE_W-1] ? ({1'b0, ~s_tdata} + MAG_W'(1))
                                                    : {1'b0, s_tdata};
                    if (cmd_t'(s_tuser) == CMD_TICK) begin
                        if (level_reg > threshold_reg) begin
                            elapsed_next = '0;
                        end else if (elapsed_reg != ELAPSED_MAX) begin
                            elapsed_next = elapsed_reg + LEVEL_W'(1);
                        end
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                sq_next    = product[SQ_W-1:0];
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                sum_next   = sum_reg + SUM_W'(sq_reg);
                count_next = count_inc;
                if (last_reg || count_inc == CNT_W'(MAX_BLOCK)) begin
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W - 1);
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                rem_next  = unit_ok ? unit_diff[UNIT_W-1:0] : unit_a;
                sum_next  = {sum_reg[SUM_W-2:0], unit_ok};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rem_next  = unit_ok ? unit_diff[UNIT_W-1:0] : unit_a;
                root_next = {root_reg[LEVEL_W-2:0], unit_ok};
                sum_next  = {sum_reg[SUM_W-3:0], 2'b00};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    level_next = {root_reg[LEVEL_W-2:0], unit_ok};
                    sum_next   = '0;
                    count_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_talk_next  = (elapsed_reg < release_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            threshold_reg <= THRESHOLD_RESET;
            release_reg   <= RELEASE_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            elapsed_reg   <= ELAPSED_MAX;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            threshold_reg <= threshold_next;
            release_reg   <= release_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        sq_reg        <= sq_next;
        last_reg      <= last_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        step_reg      <= step_next;
        out_level_reg <= out_level_next;
        out_talk_reg  <= out_talk_next;
    end

`ifndef SYNTHESIS
    // The divisor is never zero while the quotient is being formed.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (count_reg != '0))
        else $error("divide started with a zero sample count");

    // The sample count never passes the block limit.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_W'(MAX_BLOCK)))
        else $error("sample count exceeded the block limit");

    // The level cannot exceed full scale.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg <= LEVEL_FULL))
        else $error("level above full scale");

    // Leaving the emit state loads the result and returns to idle, the only state that takes a new transaction.
    a_emit_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!out_valid_reg || m_tready))
            |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result not loaded when leaving the emit state");
`endif

endmodule
